// ===== sv/slx_pkg.sv =====
`default_nettype none
package slx_pkg;
  localparam int POS_BITS_DEF  = 32;
  localparam int LEN_BITS_DEF  = 16;
  localparam int LINE_BITS_DEF = 16;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_COMMENT, M_BANG, M_EQUAL, M_GREATER, M_LESS,
    M_IDENT, M_INT, M_DOT, M_FRAC, M_STRING
  } mode_t;

  localparam logic [5:0] K_LPAREN = 6'd0;
  localparam logic [5:0] K_RPAREN = 6'd1;
  localparam logic [5:0] K_LBRACE = 6'd2;
  localparam logic [5:0] K_RBRACE = 6'd3;
  localparam logic [5:0] K_COMMA  = 6'd4;
  localparam logic [5:0] K_DOT    = 6'd5;
  localparam logic [5:0] K_MINUS  = 6'd6;
  localparam logic [5:0] K_PLUS   = 6'd7;
  localparam logic [5:0] K_SEMI   = 6'd8;
  localparam logic [5:0] K_SLASH  = 6'd9;
  localparam logic [5:0] K_STAR   = 6'd10;
  localparam logic [5:0] K_BANG   = 6'd11;
  localparam logic [5:0] K_IDENT  = 6'd19;
  localparam logic [5:0] K_STRING = 6'd20;
  localparam logic [5:0] K_NUMBER = 6'd21;
  localparam logic [5:0] K_ERROR  = 6'd36;
  localparam logic [5:0] K_EOF    = 6'd37;

  localparam logic [1:0] E_NONE  = 2'd0;
  localparam logic [1:0] E_CHAR  = 2'd1;
  localparam logic [1:0] E_UNTERM = 2'd2;

  typedef struct packed {
    logic [5:0]  kind;
    logic [47:0] start;
    logic [31:0] len;
    logic [31:0] line;
    logic [1:0]  err;
  } tok_t;

  function automatic logic [5:0] word_kind(input logic [47:0] w, input logic [2:0] n);
    logic [5:0] k;
    k = K_IDENT;
    case (n)
      3'd2: begin
        if (w[15:0] == "fi") k = 6'd28;
        if (w[15:0] == "ro") k = 6'd30;
      end
      3'd3: begin
        if (w[23:0] == "dna") k = 6'd22;
        if (w[23:0] == "rof") k = 6'd26;
        if (w[23:0] == "nuf") k = 6'd27;
        if (w[23:0] == "lin") k = 6'd29;
        if (w[23:0] == "rav") k = 6'd34;
      end
      3'd4: if (w[31:0] == "esle") k = 6'd24;
      3'd5: begin
        if (w[39:0] == "ssalc") k = 6'd23;
        if (w[39:0] == "eslaf") k = 6'd25;
        if (w[39:0] == "tnirp") k = 6'd31;
        if (w[39:0] == "repus") k = 6'd33;
        if (w[39:0] == "elihw") k = 6'd35;
      end
      3'd6: if (w == "nruter") k = 6'd32;
      default: k = K_IDENT;
    endcase
    return k;
  endfunction
endpackage
`default_nettype wire

// ===== sv/slx_if.sv =====
`default_nettype none
interface slx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_source;
  modport source (output valid, ch, end_of_source, input ready);
  modport sink (input valid, ch, end_of_source, output ready);
endinterface

interface slx_out_if #(parameter int POS_BITS = 32, parameter int LEN_BITS = 16,
                       parameter int LINE_BITS = 16);
  logic                 valid;
  logic                 ready;
  logic [5:0]           token_kind;
  logic [POS_BITS-1:0]  start_offset;
  logic [LEN_BITS-1:0]  token_length;
  logic [LINE_BITS-1:0] line_number;
  logic [1:0]           error_kind;
  logic                 last_of_run;
  modport source (output valid, token_kind, start_offset, token_length, line_number,
                  error_kind, last_of_run, input ready);
  modport sink (input valid, token_kind, start_offset, token_length, line_number,
                error_kind, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== sv/script_lexer_unit.sv =====
`default_nettype none
// Streaming scanner: one source byte is taken per cycle while the eight-entry
// token queue has room for three more tokens; each byte yields up to three
// tokens, delivered one per cycle from the queue head while tok.ready is high,
// so a run of bursts can hold the input back until the queue drains.
module script_lexer_unit import slx_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF,
  parameter int LEN_BITS = LEN_BITS_DEF,
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  slx_in_if.sink   src,
  slx_out_if.source tok
);
  logic take, room, hv, hl;
  logic [1:0] n_tok;
  tok_t t0, t1, t2, head;

  slx_front #(.POS_BITS(POS_BITS), .LEN_BITS(LEN_BITS), .LINE_BITS(LINE_BITS)) u_front (
    .clk, .rst, .in_valid(src.valid), .ch(src.ch), .end_of_source(src.end_of_source),
    .take, .room, .n_tok, .tok0(t0), .tok1(t1), .tok2(t2)
  );

  slx_queue u_queue (
    .clk, .rst, .push(take), .n_push(n_tok), .tok0(t0), .tok1(t1), .tok2(t2),
    .room, .head_valid(hv), .head, .head_last(hl), .pop(tok.ready)
  );

  assign src.ready = room;
  assign tok.valid = hv;
  assign tok.token_kind = head.kind;
  assign tok.start_offset = head.start[POS_BITS-1:0];
  assign tok.token_length = head.len[LEN_BITS-1:0];
  assign tok.line_number = head.line[LINE_BITS-1:0];
  assign tok.error_kind = head.err;
  assign tok.last_of_run = hl;
endmodule
`default_nettype wire

// ===== sv/slx_front.sv =====
`default_nettype none
module slx_front import slx_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF,
  parameter int LEN_BITS = LEN_BITS_DEF,
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [7:0] ch,
  input  wire logic       end_of_source,
  output logic            take,
  input  wire logic       room,
  output logic [1:0]      n_tok,
  output tok_t            tok0,
  output tok_t            tok1,
  output tok_t            tok2
);
  localparam logic [LEN_BITS-1:0]  LMAX = '1;
  localparam logic [LINE_BITS-1:0] NMAX = '1;

  mode_t                mode, mode_next;
  logic [47:0]          word, word_next;
  logic [POS_BITS-1:0]  tstart, tstart_next;
  logic [LEN_BITS-1:0]  count, count_next;
  logic [POS_BITS-1:0]  pos;
  logic [LINE_BITS-1:0] line, line_next;

  tok_t t [3];
  logic [1:0] n;
  logic at_end, isal, isdg, flush_it, idle_it;
  logic [LEN_BITS-1:0] c1, c2;
  logic [LINE_BITS-1:0] lflush;

  assign take = in_valid && room;
  assign at_end = end_of_source || ch == 8'd0;
  assign isal = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
  assign isdg = ch >= "0" && ch <= "9";
  assign c1 = (count == LMAX) ? count : count + 1'b1;
  assign c2 = (c1 == LMAX) ? c1 : c1 + 1'b1;

  function automatic tok_t mk(input logic [5:0] k, input logic [POS_BITS-1:0] s,
                              input logic [LEN_BITS-1:0] l, input logic [LINE_BITS-1:0] ln,
                              input logic [1:0] e);
    tok_t r;
    r = '0;
    r.kind = k;
    r.start = 48'(s);
    r.len = 32'(l);
    r.line = 32'(ln);
    r.err = e;
    return r;
  endfunction

  always_comb begin
    mode_next = mode;
    word_next = word;
    tstart_next = tstart;
    count_next = count;
    line_next = line;
    n = 2'd0;
    t[0] = '0;
    t[1] = '0;
    t[2] = '0;
    flush_it = 1'b0;
    idle_it = 1'b0;
    lflush = line;
    if (at_end) begin
      flush_it = 1'b1;
    end else begin
      case (mode)
        M_IDLE: idle_it = 1'b1;
        M_SLASH: begin
          if (ch == "/") mode_next = M_COMMENT;
          else begin flush_it = 1'b1; idle_it = 1'b1; end
        end
        M_COMMENT: if (ch == 8'h0a) idle_it = 1'b1;
        M_BANG, M_EQUAL, M_GREATER, M_LESS: begin
          if (ch == "=") begin
            t[0] = mk(K_BANG + 6'(2 * (int'(mode) - int'(M_BANG))) + 6'd1, tstart,
                      LEN_BITS'(2), line, E_NONE);
            n = 2'd1;
            mode_next = M_IDLE;
          end else begin flush_it = 1'b1; idle_it = 1'b1; end
        end
        M_IDENT: begin
          if (isal || isdg) begin
            case (count)
              LEN_BITS'(1): word_next[15:8] = ch;
              LEN_BITS'(2): word_next[23:16] = ch;
              LEN_BITS'(3): word_next[31:24] = ch;
              LEN_BITS'(4): word_next[39:32] = ch;
              LEN_BITS'(5): word_next[47:40] = ch;
              default: ;
            endcase
            count_next = c1;
          end else begin flush_it = 1'b1; idle_it = 1'b1; end
        end
        M_INT: begin
          if (isdg) count_next = c1;
          else if (ch == ".") mode_next = M_DOT;
          else begin flush_it = 1'b1; idle_it = 1'b1; end
        end
        M_DOT: begin
          if (isdg) begin count_next = c2; mode_next = M_FRAC; end
          else begin flush_it = 1'b1; idle_it = 1'b1; end
        end
        M_FRAC: begin
          if (isdg) count_next = c1;
          else begin flush_it = 1'b1; idle_it = 1'b1; end
        end
        M_STRING: begin
          count_next = c1;
          if (ch == "\"") begin
            t[0] = mk(K_STRING, tstart, c1, line, E_NONE);
            n = 2'd1;
            mode_next = M_IDLE;
          end else if (ch == 8'h0a) begin
            line_next = (line == NMAX) ? line : line + 1'b1;
          end
        end
        default: idle_it = 1'b1;
      endcase
    end
    if (flush_it) begin
      case (mode)
        M_SLASH: begin t[0] = mk(K_SLASH, tstart, LEN_BITS'(1), lflush, E_NONE); n = 2'd1; end
        M_BANG, M_EQUAL, M_GREATER, M_LESS: begin
          t[0] = mk(K_BANG + 6'(2 * (int'(mode) - int'(M_BANG))), tstart, LEN_BITS'(1),
                    lflush, E_NONE);
          n = 2'd1;
        end
        M_IDENT: begin
          t[0] = mk((count > LEN_BITS'(6)) ? K_IDENT : word_kind(word, count[2:0]), tstart,
                    count, lflush, E_NONE);
          n = 2'd1;
        end
        M_INT, M_FRAC: begin t[0] = mk(K_NUMBER, tstart, count, lflush, E_NONE); n = 2'd1; end
        M_DOT: begin
          t[0] = mk(K_NUMBER, tstart, count, lflush, E_NONE);
          t[1] = mk(K_DOT, pos - 1'b1, LEN_BITS'(1), lflush, E_NONE);
          n = 2'd2;
        end
        M_STRING: begin t[0] = mk(K_ERROR, tstart, '0, lflush, E_UNTERM); n = 2'd1; end
        default: ;
      endcase
      mode_next = M_IDLE;
    end
    if (at_end) begin
      t[n] = mk(K_EOF, pos, '0, line, E_NONE);
      n = n + 2'd1;
    end
    if (idle_it) begin
      mode_next = M_IDLE;
      case (ch)
        " ", 8'h0d, 8'h09: ;
        8'h0a: line_next = (line == NMAX) ? line : line + 1'b1;
        "(": begin t[n] = mk(K_LPAREN, pos, LEN_BITS'(1), line, E_NONE); n = n + 2'd1; end
        ")": begin t[n] = mk(K_RPAREN, pos, LEN_BITS'(1), line, E_NONE); n = n + 2'd1; end
        "{": begin t[n] = mk(K_LBRACE, pos, LEN_BITS'(1), line, E_NONE); n = n + 2'd1; end
        "}": begin t[n] = mk(K_RBRACE, pos, LEN_BITS'(1), line, E_NONE); n = n + 2'd1; end
        ",": begin t[n] = mk(K_COMMA, pos, LEN_BITS'(1), line, E_NONE); n = n + 2'd1; end
        ".": begin t[n] = mk(K_DOT, pos, LEN_BITS'(1), line, E_NONE); n = n + 2'd1; end
        "-": begin t[n] = mk(K_MINUS, pos, LEN_BITS'(1), line, E_NONE); n = n + 2'd1; end
        "+": begin t[n] = mk(K_PLUS, pos, LEN_BITS'(1), line, E_NONE); n = n + 2'd1; end
        ";": begin t[n] = mk(K_SEMI, pos, LEN_BITS'(1), line, E_NONE); n = n + 2'd1; end
        "*": begin t[n] = mk(K_STAR, pos, LEN_BITS'(1), line, E_NONE); n = n + 2'd1; end
        "/": begin mode_next = M_SLASH; tstart_next = pos; count_next = LEN_BITS'(1); end
        "!": begin mode_next = M_BANG; tstart_next = pos; count_next = LEN_BITS'(1); end
        "=": begin mode_next = M_EQUAL; tstart_next = pos; count_next = LEN_BITS'(1); end
        ">": begin mode_next = M_GREATER; tstart_next = pos; count_next = LEN_BITS'(1); end
        "<": begin mode_next = M_LESS; tstart_next = pos; count_next = LEN_BITS'(1); end
        "\"": begin mode_next = M_STRING; tstart_next = pos; count_next = LEN_BITS'(1); end
        default: begin
          if (isal) begin
            mode_next = M_IDENT; tstart_next = pos; count_next = LEN_BITS'(1);
            word_next = {40'd0, ch};
          end else if (isdg) begin
            mode_next = M_INT; tstart_next = pos; count_next = LEN_BITS'(1);
          end else begin
            t[n] = mk(K_ERROR, pos, '0, line, E_CHAR);
            n = n + 2'd1;
          end
        end
      endcase
    end
    n_tok = n;
    tok0 = t[0];
    tok1 = t[1];
    tok2 = t[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      word <= '0;
      tstart <= '0;
      count <= '0;
      pos <= '0;
      line <= LINE_BITS'(1);
    end else if (take) begin
      if (at_end) begin
        mode <= M_IDLE;
        word <= '0;
        tstart <= '0;
        count <= '0;
        pos <= '0;
        line <= LINE_BITS'(1);
      end else begin
        mode <= mode_next;
        word <= word_next;
        tstart <= tstart_next;
        count <= count_next;
        pos <= pos + 1'b1;
        line <= line_next;
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/slx_queue.sv =====
`default_nettype none
module slx_queue import slx_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic [1:0] n_push,
  input  wire tok_t       tok0,
  input  wire tok_t       tok1,
  input  wire tok_t       tok2,
  output logic            room,
  output logic            head_valid,
  output tok_t            head,
  output logic            head_last,
  input  wire logic       pop
);
  localparam int DEPTH = 8;
  tok_t       mem  [DEPTH];
  logic       lst  [DEPTH];
  logic [2:0] wp, rp;
  logic [3:0] fill;
  logic [1:0] np;
  logic       popd;

  assign np = push ? n_push : 2'd0;
  assign popd = pop && head_valid;
  assign room = fill <= 4'd5;
  assign head_valid = fill != 4'd0;
  assign head = mem[rp];
  assign head_last = lst[rp];

  always_ff @(posedge clk) begin
    if (np >= 2'd1) begin
      mem[wp] <= tok0;
      lst[wp] <= np == 2'd1;
    end
    if (np >= 2'd2) begin
      mem[wp + 3'd1] <= tok1;
      lst[wp + 3'd1] <= np == 2'd2;
    end
    if (np == 2'd3) begin
      mem[wp + 3'd2] <= tok2;
      lst[wp + 3'd2] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
    end else begin
      wp <= wp + 3'(np);
      rp <= rp + 3'(popd);
      fill <= fill + 4'(np) - 4'(popd);
    end
  end
endmodule
`default_nettype wire

// ===== sv/slx_checker.sv =====
`default_nettype none
module slx_checker import slx_pkg::*; #(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [5:0]          kind,
  input wire logic [1:0]          err,
  input wire logic [LEN_BITS-1:0] len
);
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid) else $error("request withdrawn");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind)) else $error("token dropped");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind <= K_EOF) else $error("bad kind");
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && err != E_NONE |-> kind == K_ERROR && len == '0) else $error("bad error");
  a_idle: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("output after reset");
endmodule

bind script_lexer_unit slx_checker #(.LEN_BITS(LEN_BITS)) u_chk (
  .clk, .rst, .in_valid(src.valid), .in_ready(src.ready), .out_valid(tok.valid),
  .out_ready(tok.ready), .kind(tok.token_kind), .err(tok.error_kind),
  .len(tok.token_length)
);
`default_nettype wire
